/* rtl/category_vlc_bit_packer_defines.svh */
// Assertion macros used by the bound checker module.
`ifndef CATEGORY_VLC_BIT_PACKER_DEFINES_SVH
`define CATEGORY_VLC_BIT_PACKER_DEFINES_SVH

// Assert a property on a given clock, disabled while reset is active.
`define CVBP_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cvbp checker: property failed");

// Assert a property on the block clock and reset.
`define CVBP_ASSERT(lbl, prop) `CVBP_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

/* rtl/cvbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cvbp_pkg;

  // Word and code geometry
  localparam int WordBits   = 32;
  localparam int CountW     = $clog2(WordBits);
  localparam int ValidW     = $clog2(WordBits) + 1;
  localparam int CoefW      = 14;
  localparam int MagW       = CoefW - 1;
  localparam int CatW       = 4;
  localparam int PrefixW    = 11;
  localparam int PrefixLenW = 4;
  localparam int CodeW      = 24;
  localparam int CodeLenW   = 5;
  localparam int PendW      = WordBits - 1;
  localparam int AccW       = PendW + CodeW;
  localparam int TotalW     = $clog2(AccW + 1);

  // Output queue geometry
  localparam int QueueDepth = 4;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Code length of a zero coefficient
  localparam logic [CodeLenW-1:0] ZeroLen = CodeLenW'(2);

  // One encoded symbol
  typedef struct packed {
    logic [CodeW-1:0]    code;
    logic [CodeLenW-1:0] len;
    logic                eob;
  } sym_t;

  // One result transaction
  typedef struct packed {
    logic [WordBits-1:0] packed_word;
    logic [ValidW-1:0]   valid_bits;
    logic                block_end;
  } result_t;

  // Results produced by one packing step
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Prefix code of a category, right-aligned
  function automatic logic [PrefixW-1:0] prefix_code(input logic [CatW-1:0] cat);
    logic [PrefixW-1:0] p;
    unique case (cat)
      4'd1:    p = 11'h002;
      4'd2:    p = 11'h003;
      4'd3:    p = 11'h004;
      4'd4:    p = 11'h005;
      4'd5:    p = 11'h006;
      4'd6:    p = 11'h00E;
      4'd7:    p = 11'h01E;
      4'd8:    p = 11'h03E;
      4'd9:    p = 11'h07E;
      4'd10:   p = 11'h0FE;
      4'd11:   p = 11'h1FE;
      4'd12:   p = 11'h3FE;
      4'd13:   p = 11'h7FE;
      default: p = 11'h000;
    endcase
    return p;
  endfunction

  // Prefix length of a category
  function automatic logic [PrefixLenW-1:0] prefix_len(input logic [CatW-1:0] cat);
    logic [PrefixLenW-1:0] l;
    unique case (cat)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5: l = 4'd3;
      4'd6:    l = 4'd4;
      4'd7:    l = 4'd5;
      4'd8:    l = 4'd6;
      4'd9:    l = 4'd7;
      4'd10:   l = 4'd8;
      4'd11:   l = 4'd9;
      4'd12:   l = 4'd10;
      4'd13:   l = 4'd11;
      default: l = 4'd2;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

/* rtl/cvbp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Coefficient channel
interface cvbp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cvbp_pkg::CoefW-1:0]   coefficient;
  logic                                end_of_block;

  modport source (output valid, output coefficient, output end_of_block, input ready);
  modport sink   (input valid, input coefficient, input end_of_block, output ready);
endinterface

// Packed word channel
interface cvbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [cvbp_pkg::WordBits-1:0] packed_word;
  logic [cvbp_pkg::ValidW-1:0]   valid_bits;
  logic                          block_end;

  modport source (output valid, output packed_word, output valid_bits, output block_end,
                  input ready);
  modport sink   (input valid, input packed_word, input valid_bits, input block_end,
                  output ready);
endinterface

`default_nettype wire

/* rtl/cvbp_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none

module cvbp_encoder (
  input  wire logic signed [cvbp_pkg::CoefW-1:0] coefficient_i,
  input  wire logic                              end_of_block_i,
  output cvbp_pkg::sym_t                         sym_o
);

  logic                             neg;
  logic [cvbp_pkg::CoefW-1:0]       mag_full;
  logic [cvbp_pkg::MagW-1:0]        mag;
  logic [cvbp_pkg::CatW-1:0]        cat;
  logic [cvbp_pkg::CatW-1:0]        low_cnt;
  logic [cvbp_pkg::CodeW-1:0]       head;
  logic [cvbp_pkg::CodeW-1:0]       low_mask;

  // Take the magnitude, saturating the most negative pattern
  always_comb begin
    neg      = coefficient_i[cvbp_pkg::CoefW-1];
    mag_full = neg ? (~coefficient_i + cvbp_pkg::CoefW'(1)) : coefficient_i;
    mag      = mag_full[cvbp_pkg::CoefW-1] ? {cvbp_pkg::MagW{1'b1}}
                                           : mag_full[cvbp_pkg::MagW-1:0];
  end

  // Category is the bit length of the magnitude
  always_comb begin
    cat = '0;
    for (int i = 0; i < cvbp_pkg::MagW; i++) begin
      if (mag[i]) cat = cvbp_pkg::CatW'(i + 1);
    end
  end

  // Build prefix, sign and low magnitude bits
  always_comb begin
    low_cnt  = cat - cvbp_pkg::CatW'(1);
    head     = cvbp_pkg::CodeW'({cvbp_pkg::prefix_code(cat), ~neg}) << low_cnt;
    low_mask = (cvbp_pkg::CodeW'(1) << low_cnt) - cvbp_pkg::CodeW'(1);
    sym_o.eob = end_of_block_i;
    if (cat == '0) begin
      sym_o.code = '0;
      sym_o.len  = cvbp_pkg::ZeroLen;
    end else begin
      sym_o.code = head | (cvbp_pkg::CodeW'(mag) & low_mask);
      sym_o.len  = cvbp_pkg::CodeLenW'(cvbp_pkg::prefix_len(cat)) + cvbp_pkg::CodeLenW'(cat);
    end
  end

endmodule

`default_nettype wire

/* rtl/cvbp_packer.sv */
`timescale 1ns / 1ps
`default_nettype none

module cvbp_packer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            sym_valid_i,
  output logic                 sym_ready_o,
  input  wire cvbp_pkg::sym_t  sym_i,
  input  wire logic            space_i,
  output cvbp_pkg::push_t      push_o
);

  logic                            a_vld_q, a_vld_d;
  cvbp_pkg::sym_t                  a_q;
  logic [cvbp_pkg::PendW-1:0]      pend_q, pend_d;
  logic [cvbp_pkg::CountW-1:0]     pcnt_q, pcnt_d;

  logic                            fire;
  logic                            load;
  logic [cvbp_pkg::AccW-1:0]       acc;
  logic [cvbp_pkg::TotalW-1:0]     total;
  logic                            full;
  logic [cvbp_pkg::CountW-1:0]     rest;
  logic [cvbp_pkg::AccW-1:0]       rest_mask;
  logic [cvbp_pkg::WordBits-1:0]   full_word;
  logic [cvbp_pkg::PendW-1:0]      rem_bits;
  logic [cvbp_pkg::CountW-1:0]     rem_cnt;
  logic                            flush;
  logic [cvbp_pkg::ValidW-1:0]     pad;
  cvbp_pkg::result_t               full_res;
  cvbp_pkg::result_t               flush_res;

  // Advance the symbol stage when the queue has room for two results
  assign fire        = a_vld_q && space_i;
  assign sym_ready_o = !a_vld_q || fire;
  assign load        = sym_valid_i && sym_ready_o;

  // Append the code behind the pending bits and split off a full word
  always_comb begin
    acc       = (cvbp_pkg::AccW'(pend_q) << a_q.len) | cvbp_pkg::AccW'(a_q.code);
    total     = cvbp_pkg::TotalW'(pcnt_q) + cvbp_pkg::TotalW'(a_q.len);
    full      = total >= cvbp_pkg::TotalW'(cvbp_pkg::WordBits);
    rest      = cvbp_pkg::CountW'(total - cvbp_pkg::TotalW'(cvbp_pkg::WordBits));
    rest_mask = (cvbp_pkg::AccW'(1) << rest) - cvbp_pkg::AccW'(1);
    full_word = cvbp_pkg::WordBits'(acc >> rest);
    rem_bits  = full ? cvbp_pkg::PendW'(acc & rest_mask) : cvbp_pkg::PendW'(acc);
    rem_cnt   = full ? rest : cvbp_pkg::CountW'(total);
    flush     = a_q.eob && (rem_cnt != '0);
    pad       = cvbp_pkg::ValidW'(cvbp_pkg::WordBits) - cvbp_pkg::ValidW'(rem_cnt);
  end

  // Form the full word and the flush word
  always_comb begin
    full_res.packed_word  = full_word;
    full_res.valid_bits   = cvbp_pkg::ValidW'(cvbp_pkg::WordBits);
    full_res.block_end    = a_q.eob && !flush;
    flush_res.packed_word = cvbp_pkg::WordBits'(rem_bits) << pad;
    flush_res.valid_bits  = cvbp_pkg::ValidW'(rem_cnt);
    flush_res.block_end   = 1'b1;

    push_o.count  = fire ? (2'(full) + 2'(flush)) : 2'd0;
    push_o.first  = full ? full_res : flush_res;
    push_o.second = flush_res;
  end

  // Update the pending bits; a block end empties them
  always_comb begin
    a_vld_d = a_vld_q;
    pend_d  = pend_q;
    pcnt_d  = pcnt_q;
    if (fire) begin
      a_vld_d = 1'b0;
      pend_d  = a_q.eob ? '0 : rem_bits;
      pcnt_d  = a_q.eob ? '0 : rem_cnt;
    end
    if (load) a_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      pend_q  <= '0;
      pcnt_q  <= '0;
    end else begin
      a_vld_q <= a_vld_d;
      pend_q  <= pend_d;
      pcnt_q  <= pcnt_d;
    end
  end

  // Hold the symbol until it is packed
  always_ff @(posedge clk_i) begin
    if (load) a_q <= sym_i;
  end

endmodule

`default_nettype wire

/* rtl/cvbp_out_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module cvbp_out_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cvbp_pkg::push_t push_i,
  output logic                 space_o,
  cvbp_out_if.source           out_o
);

  cvbp_pkg::result_t                 ent_q [cvbp_pkg::QueueDepth];
  cvbp_pkg::result_t                 ent_d [cvbp_pkg::QueueDepth];
  logic [cvbp_pkg::QueueCntW-1:0]    cnt_q, cnt_d;
  logic [cvbp_pkg::QueueCntW-1:0]    base;
  logic                              pop;

  // Drive the head entry
  assign out_o.valid       = cnt_q != '0;
  assign out_o.packed_word = ent_q[0].packed_word;
  assign out_o.valid_bits  = ent_q[0].valid_bits;
  assign out_o.block_end   = ent_q[0].block_end;

  assign pop     = out_o.valid && out_o.ready;
  assign base    = cnt_q - cvbp_pkg::QueueCntW'(pop);
  assign space_o = base <= cvbp_pkg::QueueCntW'(cvbp_pkg::QueueDepth - 2);

  // Shift toward the head on pop, append new results behind the survivors
  always_comb begin
    for (int i = 0; i < cvbp_pkg::QueueDepth - 1; i++) begin
      ent_d[i] = pop ? ent_q[i+1] : ent_q[i];
    end
    ent_d[cvbp_pkg::QueueDepth-1] = ent_q[cvbp_pkg::QueueDepth-1];
    for (int i = 0; i < cvbp_pkg::QueueDepth; i++) begin
      if (push_i.count != 2'd0 && cvbp_pkg::QueueCntW'(i) == base) ent_d[i] = push_i.first;
      if (push_i.count == 2'd2 &&
          cvbp_pkg::QueueCntW'(i) == base + cvbp_pkg::QueueCntW'(1)) begin
        ent_d[i] = push_i.second;
      end
    end
    cnt_d = base + cvbp_pkg::QueueCntW'(push_i.count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

/* rtl/category_vlc_bit_packer.sv */
// Path: the symbol stage and then the 4-entry result queue register each code before output.
// Throughput: one coefficient per cycle while the queue has room for two results; a block
//   end that yields a full word and a flush word puts both on the single output port in turn.
// Reset (asynchronous, active low): pending bits and fill count cleared, symbol
//   stage and result queue emptied.
`timescale 1ns / 1ps
`default_nettype none

module category_vlc_bit_packer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cvbp_in_if.sink    in_i,
  cvbp_out_if.source out_o
);

  cvbp_pkg::sym_t  sym;
  cvbp_pkg::push_t push;
  logic            space;
  logic            sym_ready;

  assign in_i.ready = sym_ready;

  // Map each coefficient to its code
  cvbp_encoder u_encoder (
    .coefficient_i  (in_i.coefficient),
    .end_of_block_i (in_i.end_of_block),
    .sym_o          (sym)
  );

  // Pack codes into words
  cvbp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sym_valid_i (in_i.valid),
    .sym_ready_o (sym_ready),
    .sym_i       (sym),
    .space_i     (space),
    .push_o      (push)
  );

  // Queue results for the output channel
  cvbp_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

/* rtl/cvbp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "category_vlc_bit_packer_defines.svh"

module cvbp_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [cvbp_pkg::WordBits-1:0] packed_word_i,
  input wire logic [cvbp_pkg::ValidW-1:0]   valid_bits_i,
  input wire logic                          block_end_i
);

  // A stalled word stays offered
  `CVBP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)

  // Fill count stays within one word
  `CVBP_ASSERT(a_valid_range, out_valid_i |-> valid_bits_i != '0 &&
    valid_bits_i <= cvbp_pkg::ValidW'(cvbp_pkg::WordBits))

  // Only a flush carries a partial word
  `CVBP_ASSERT(a_partial_end, out_valid_i &&
    valid_bits_i != cvbp_pkg::ValidW'(cvbp_pkg::WordBits) |-> block_end_i)

  // Padding behind the meaningful bits is zero
  `CVBP_ASSERT(a_zero_pad, out_valid_i &&
    valid_bits_i != cvbp_pkg::ValidW'(cvbp_pkg::WordBits) |->
    (packed_word_i << valid_bits_i) == '0)

endmodule

bind category_vlc_bit_packer cvbp_checker u_cvbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .packed_word_i (out_o.packed_word),
  .valid_bits_i  (out_o.valid_bits),
  .block_end_i   (out_o.block_end)
);

`default_nettype wire

/* verif/category_vlc_bit_packer_checker.sv */
`timescale 1ns / 1ps

// Watch both channels, predict the packed words and compare them in order.
module category_vlc_bit_packer_checker (
  input  logic clk_i,
  input  logic rst_ni,
  cvbp_in_if   coef_i,
  cvbp_out_if  word_i,
  output int   mismatches_o,
  output int   words_due_o,
  output int   words_seen_o,
  output int   flushes_o
);
  import cvbp_pkg::*;

  localparam int ReportLimit = 10;

  // Bits waiting for a word, right-aligned, and their count
  logic [63:0] fill_bits;
  int unsigned fill_count;
  result_t     expected_words[$];

  // Build the variable-length code of one coefficient
  function automatic void vlc_code(input logic [CoefW-1:0] raw, output logic [63:0] code,
                                   output int unsigned len);
    logic              neg;
    logic [CoefW-1:0]  mag;
    int unsigned       cat;
    logic [63:0]       prefix;
    int unsigned       prefix_bits;
    neg = raw[CoefW-1];
    mag = neg ? CoefW'(0) - raw : raw;
    // The most negative pattern saturates to the largest magnitude
    if (mag > 14'd8191) mag = 14'd8191;
    cat = 0;
    while (cat < 13 && (mag >> cat) != 0) cat++;
    if (cat == 0) begin
      code = '0;
      len  = 2;
      return;
    end
    // Short prefixes count up from 010, long ones are a run of ones ended by a zero
    if (cat <= 5) begin
      prefix      = 64'(cat + 1);
      prefix_bits = 3;
    end else begin
      prefix      = ((64'd1 << (cat - 3)) - 64'd1) << 1;
      prefix_bits = cat - 2;
    end
    code = (prefix << cat) | (64'(!neg) << (cat - 1))
         | (64'(mag) & ((64'd1 << (cat - 1)) - 64'd1));
    len  = prefix_bits + cat;
  endfunction

  // Append one code to the fill and queue every word that it completes
  function automatic void pack_coefficient(input logic [CoefW-1:0] raw, input logic eob);
    logic [63:0] code;
    int unsigned len;
    int unsigned room;
    int unsigned rest;
    int          produced;
    result_t     word;
    produced = 0;
    vlc_code(raw, code, len);
    while (len > 0) begin
      room = WordBits - fill_count;
      if (len < room) begin
        fill_bits  = (fill_bits << len) | code;
        fill_count = fill_count + len;
        len        = 0;
      end else begin
        rest             = len - room;
        word.packed_word = WordBits'((fill_bits << room) | (code >> rest));
        word.valid_bits  = ValidW'(WordBits);
        word.block_end   = 1'b0;
        expected_words.push_back(word);
        produced++;
        code       = code & ((64'd1 << rest) - 64'd1);
        len        = rest;
        fill_bits  = '0;
        fill_count = 0;
      end
    end
    if (eob) begin
      if (fill_count > 0) begin
        // Flush the partial word, left-aligned with zero padding
        word.packed_word = WordBits'(fill_bits << (WordBits - fill_count));
        word.valid_bits  = ValidW'(fill_count);
        word.block_end   = 1'b1;
        expected_words.push_back(word);
        fill_bits  = '0;
        fill_count = 0;
      end else if (produced > 0) begin
        // Block ended on a word boundary: the full word closes it
        expected_words[expected_words.size() - 1].block_end = 1'b1;
      end
    end
  endfunction

  // Predict on each coefficient transaction, check each word transaction
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      fill_bits = '0;
      fill_count = 0;
      expected_words.delete();
      mismatches_o <= 0;
      words_due_o  <= 0;
      words_seen_o <= 0;
      flushes_o    <= 0;
    end else begin
      if (coef_i.valid && coef_i.ready) begin
        pack_coefficient(coef_i.coefficient, coef_i.end_of_block);
      end
      if (word_i.valid && word_i.ready) begin
        got.packed_word = word_i.packed_word;
        got.valid_bits  = word_i.valid_bits;
        got.block_end   = word_i.block_end;
        words_seen_o <= words_seen_o + 1;
        if (got.valid_bits != ValidW'(WordBits)) flushes_o <= flushes_o + 1;
        if (expected_words.size() == 0) begin
          if (mismatches_o < ReportLimit) begin
            $display("%0t: unexpected word %h valid_bits %0d block_end %0b", $realtime,
                     got.packed_word, got.valid_bits, got.block_end);
          end
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            if (mismatches_o < ReportLimit) begin
              $display("%0t: word mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                       $realtime, want.packed_word, want.valid_bits, want.block_end,
                       got.packed_word, got.valid_bits, got.block_end);
            end
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      words_due_o <= expected_words.size();
    end
  end

endmodule

/* verif/category_vlc_bit_packer_tb.sv */
`timescale 1ns / 1ps

// Drive coefficient blocks with random gaps and back-pressure; the checker judges.
module category_vlc_bit_packer_tb;
  import cvbp_pkg::*;

  localparam int RandomItems = 1400;
  localparam int CycleLimit  = 400000;
  localparam int IdlePercent = 30;

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int   cycle_count;
  int   coefs_sent;
  int   blocks_sent;
  int   mismatches;
  int   words_due;
  int   words_seen;
  int   flushes;
  int   block_len;

  cvbp_in_if  in_if ();
  cvbp_out_if out_if ();

  category_vlc_bit_packer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  category_vlc_bit_packer_checker packer_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coef_i       (in_if),
    .word_i       (out_if),
    .mismatches_o (mismatches),
    .words_due_o  (words_due),
    .words_seen_o (words_seen),
    .flushes_o    (flushes)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Stall the word channel at random, except during the calm stretch
  always @(posedge clk_i) begin
    out_if.ready <= calm || ($urandom_range(99) >= IdlePercent);
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("category_vlc_bit_packer_tb NOT OK");
      $finish;
    end
  end

  // Offer one coefficient after a random gap and hold it until the transaction
  task automatic send_coef(input logic signed [CoefW-1:0] coef, input logic eob);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.coefficient  <= coef;
    in_if.end_of_block <= eob;
    do @(posedge clk_i); while (!in_if.ready);
    coefs_sent++;
    if (eob) blocks_sent++;
  endtask

  // Drop valid and hold until every predicted word has come out
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
  endtask

  // Now and then return the most negative pattern; else pick a category uniformly, then a magnitude and sign within it
  function automatic logic signed [CoefW-1:0] random_coef();
    int unsigned      cat;
    logic [CoefW-1:0] mag;
    if ($urandom_range(49) == 0) return 14'sh2000;
    cat = $urandom_range(13);
    if (cat == 0) return '0;
    mag = CoefW'((32'd1 << (cat - 1)) | ($urandom & ((32'd1 << (cat - 1)) - 1)));
    return $urandom_range(1) ? -mag : mag;
  endfunction

  initial begin
    rst_ni             = 1'b0;
    calm               = 1'b0;
    cycle_count        = 0;
    coefs_sent         = 0;
    blocks_sent        = 0;
    in_if.valid        = 1'b0;
    in_if.coefficient  = '0;
    in_if.end_of_block = 1'b0;
    out_if.ready       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes and saturation, then a flushed partial word
    send_coef(14'sd8191, 1'b0);
    send_coef(-14'sd8192, 1'b0);
    send_coef(-14'sd8191, 1'b0);
    send_coef(14'sd1, 1'b0);
    send_coef(-14'sd1, 1'b0);
    send_coef(14'sd2, 1'b0);
    send_coef(-14'sd3, 1'b1);
    // Sixteen zeros fill exactly one word: the block ends on the boundary
    for (int i = 0; i < 16; i++) send_coef('0, i == 15);
    // A lone zero block flushes two bits
    send_coef('0, 1'b1);

    // Let the block run dry before the random part
    drain();

    // Random blocks, mostly short, now and then long ones
    while (coefs_sent < RandomItems) begin
      calm = (coefs_sent >= 700 && coefs_sent < 900);
      block_len = ($urandom_range(9) == 0) ? $urandom_range(17, 96) : $urandom_range(1, 16);
      for (int i = 0; i < block_len; i++) send_coef(random_coef(), i == block_len - 1);
    end
    calm = 1'b0;

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d coefficients in %0d blocks across all categories and saturation.",
             coefs_sent, blocks_sent);
    $display("Checked %0d words, %0d of them flushed partial words.", words_seen, flushes);
    if (mismatches == 0 && words_due == 0) begin
      $display("category_vlc_bit_packer_tb OK");
    end else begin
      $display("category_vlc_bit_packer_tb NOT OK");
    end
    $finish;
  end

endmodule
